FILE: rtl/bpsd_pkg.sv
// Package for the box point signed distance block: payload types and constants.
`default_nettype none
package bpsd_pkg;

  localparam int CoordW  = 32;
  localparam int QuatW   = 16;
  localparam int SizeW   = 31;
  localparam int CfgAddrW = 2;
  localparam int RadW    = 62;   // radicand of the distance root
  localparam int RootW   = 31;   // integer root of the radicand
  localparam int QuatLim = 16384;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] RegSizeX = 2'd0;
  localparam logic [CfgAddrW-1:0] RegSizeY = 2'd1;
  localparam logic [CfgAddrW-1:0] RegSizeZ = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] query_x;
    logic signed [CoordW-1:0] query_y;
    logic signed [CoordW-1:0] query_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic signed [QuatW-1:0]  quat_w;
    logic signed [QuatW-1:0]  quat_i;
    logic signed [QuatW-1:0]  quat_j;
    logic signed [QuatW-1:0]  quat_k;
  } bpsd_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] near_x;
    logic signed [CoordW-1:0] near_y;
    logic signed [CoordW-1:0] near_z;
    logic signed [CoordW-1:0] signed_distance;
  } bpsd_out_t;

  // Clamp a quaternion component to [-1.0, 1.0] in Q2.14
  function automatic logic signed [QuatW-1:0] quat_sat(input logic signed [QuatW-1:0] v);
    logic signed [QuatW-1:0] r;
    if (v > QuatW'(QuatLim)) r = QuatW'(QuatLim);
    else if (v < -QuatW'(QuatLim)) r = -QuatW'(QuatLim);
    else r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/box_point_signed_distance.sv
// Top level: closest point on an oriented box and signed distance, fully pipelined.
// The start beat passes the front stages, the square root and the output register before the out_valid strobe.
// Throughput: one query per cycle; busy stays low, so every start is taken.
// The depth is set by the 31-stage square root that forms the distance.
// Reset (rst_n low, synchronous) clears all valid bits and zeroes the box size registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module box_point_signed_distance (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire bpsd_pkg::bpsd_in_t                  in_data,
  output logic                                     out_valid,
  output bpsd_pkg::bpsd_out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [bpsd_pkg::CfgAddrW-1:0]       cfg_addr,
  input  wire logic [bpsd_pkg::SizeW-1:0]          cfg_wdata
);
  import bpsd_pkg::*;

  localparam int DW = CoordW + 1;   // query minus center
  localparam int MW = 32;           // rotation entry, Q.28
  localparam int PW = MW + DW;      // entry times offset
  localparam int SW = PW + 1;       // sum of three products
  localparam int UW = 39;           // doubled local coordinate
  localparam int XW = UW + 1;       // compare width
  localparam int FW = XW + 1;       // local difference
  localparam int WP = MW + CoordW;  // entry times corner
  localparam int WS = WP + 2;

  typedef logic signed [MW-1:0] mat_t [3][3];

  // Configuration registers
  logic [SizeW-1:0] size_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) size_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegSizeX: size_r[0] <= cfg_wdata;
        RegSizeY: size_r[1] <= cfg_wdata;
        RegSizeZ: size_r[2] <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: offset from center, clamp quaternion
  logic                       v1_r;
  logic signed [DW-1:0]       d1_r [3];
  logic signed [CoordW-1:0]   c1_r [3];
  logic signed [QuatW-1:0]    qw1_r, qx1_r, qy1_r, qz1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start && !busy;
    d1_r[0] <= DW'(in_data.query_x) - DW'(in_data.center_x);
    d1_r[1] <= DW'(in_data.query_y) - DW'(in_data.center_y);
    d1_r[2] <= DW'(in_data.query_z) - DW'(in_data.center_z);
    c1_r[0] <= in_data.center_x;
    c1_r[1] <= in_data.center_y;
    c1_r[2] <= in_data.center_z;
    qw1_r <= quat_sat(in_data.quat_w);
    qx1_r <= quat_sat(in_data.quat_i);
    qy1_r <= quat_sat(in_data.quat_j);
    qz1_r <= quat_sat(in_data.quat_k);
  end

  // Stage 2: rotation matrix from quaternion products
  logic                       v2_r;
  logic signed [DW-1:0]       d2_r [3];
  logic signed [CoordW-1:0]   c2_r [3];
  mat_t                       m2_r, m_nxt;
  always_comb begin
    logic signed [MW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [MW-1:0] one;
    one = MW'(1) <<< 28;
    xx = MW'(qx1_r) * MW'(qx1_r); yy = MW'(qy1_r) * MW'(qy1_r);
    zz = MW'(qz1_r) * MW'(qz1_r);
    xy = MW'(qx1_r) * MW'(qy1_r); xz = MW'(qx1_r) * MW'(qz1_r);
    yz = MW'(qy1_r) * MW'(qz1_r);
    wx = MW'(qw1_r) * MW'(qx1_r); wy = MW'(qw1_r) * MW'(qy1_r);
    wz = MW'(qw1_r) * MW'(qz1_r);
    m_nxt[0][0] = one - ((yy + zz) <<< 1);
    m_nxt[0][1] = (xy - wz) <<< 1;
    m_nxt[0][2] = (xz + wy) <<< 1;
    m_nxt[1][0] = (xy + wz) <<< 1;
    m_nxt[1][1] = one - ((xx + zz) <<< 1);
    m_nxt[1][2] = (yz - wx) <<< 1;
    m_nxt[2][0] = (xz - wy) <<< 1;
    m_nxt[2][1] = (yz + wx) <<< 1;
    m_nxt[2][2] = one - ((xx + yy) <<< 1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    d2_r <= d1_r;
    c2_r <= c1_r;
    m2_r <= m_nxt;
  end

  // Stage 3: products of transposed matrix and offset
  logic                       v3_r;
  logic signed [PW-1:0]       p3_r [3][3];
  logic signed [CoordW-1:0]   c3_r [3];
  mat_t                       m3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++)
        p3_r[k][j] <= PW'(m2_r[j][k]) * PW'(d2_r[j]);
    c3_r <= c2_r;
    m3_r <= m2_r;
  end

  // Stage 4: sum and round to doubled local coordinates
  logic                       v4_r;
  logic signed [UW-1:0]       u4_r [3];
  logic signed [CoordW-1:0]   c4_r [3];
  mat_t                       m4_r;
  always_ff @(posedge clk) begin
    logic signed [SW-1:0] acc;
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    for (int k = 0; k < 3; k++) begin
      acc = SW'(p3_r[k][0]) + SW'(p3_r[k][1]) + SW'(p3_r[k][2]) + (SW'(1) <<< 26);
      u4_r[k] <= acc[SW-1:27];
    end
    c4_r <= c3_r;
    m4_r <= m3_r;
  end

  // Stage 5: range tests and face margins
  logic                       v5_r;
  logic signed [XW-1:0]       u5_r [3];
  logic signed [XW-1:0]       b5_r [3];
  logic                       in5_r [3];
  logic signed [CoordW-1:0]   c5_r [3];
  mat_t                       m5_r;
  always_ff @(posedge clk) begin
    logic signed [XW-1:0] ux, sx, ax;
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    for (int k = 0; k < 3; k++) begin
      ux = XW'(u4_r[k]);
      sx = XW'({1'b0, size_r[k]});
      ax = (ux < 0) ? -ux : ux;
      u5_r[k]  <= ux;
      in5_r[k] <= (ux > -sx) && (ux < sx);
      b5_r[k]  <= sx - ax;
    end
    c5_r <= c4_r;
    m5_r <= m4_r;
  end

  // Stage 6: snap inside points to the nearest face, form local corner
  logic                       v6_r;
  logic                       inside6_r;
  logic signed [CoordW-1:0]   cl6_r [3];
  logic signed [FW-1:0]       df6_r [3];
  logic signed [CoordW-1:0]   c6_r [3];
  mat_t                       m6_r;
  always_ff @(posedge clk) begin
    logic in_box;
    logic keep [3];
    logic signed [XW-1:0] sx, cx;
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
    in_box = in5_r[0] && in5_r[1] && in5_r[2];
    keep = in5_r;
    if (in_box) begin
      priority if (b5_r[0] <= b5_r[1] && b5_r[0] <= b5_r[2]) keep[0] = 1'b0;
      else if (b5_r[1] <= b5_r[0] && b5_r[1] <= b5_r[2]) keep[1] = 1'b0;
      else keep[2] = 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      sx = XW'({1'b0, size_r[k]});
      if (keep[k]) cx = u5_r[k];
      else cx = (u5_r[k] < 0) ? -sx : sx;
      cl6_r[k] <= cx[CoordW-1:0];
      df6_r[k] <= FW'(cx) - FW'(u5_r[k]);
    end
    inside6_r <= in_box;
    c6_r <= c5_r;
    m6_r <= m5_r;
  end

  // Stage 7: rotate corner back, square the differences
  logic                       v7_r;
  logic                       inside7_r;
  logic                       big7_r;
  logic signed [WP-1:0]       w7_r [3][3];
  logic [2*CoordW-1:0]        sq7_r [3];
  logic signed [CoordW-1:0]   c7_r [3];
  always_ff @(posedge clk) begin
    logic [FW-1:0] a;
    logic big;
    if (!rst_n) v7_r <= 1'b0;
    else v7_r <= v6_r;
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++)
        w7_r[k][j] <= WP'(m6_r[k][j]) * WP'(cl6_r[j]);
      a = (df6_r[k] < 0) ? FW'(-df6_r[k]) : FW'(df6_r[k]);
      big = big | (|a[FW-1:CoordW]);
      sq7_r[k] <= {32'b0, a[CoordW-1:0]} * {32'b0, a[CoordW-1:0]};
    end
    big7_r <= big;
    inside7_r <= inside6_r;
    c7_r <= c6_r;
  end

  // Stage 8: round and saturate world point, sum squares
  logic                       v8_r;
  logic                       inside8_r;
  logic                       sat8_r;
  logic [RadW-1:0]            rad8_r;
  logic signed [CoordW-1:0]   near8_r [3];
  always_ff @(posedge clk) begin
    logic signed [WS-1:0] acc;
    logic signed [WS-1:0] wv;
    logic [2*CoordW+1:0]  sq;
    if (!rst_n) v8_r <= 1'b0;
    else v8_r <= v7_r;
    for (int k = 0; k < 3; k++) begin
      acc = WS'(w7_r[k][0]) + WS'(w7_r[k][1]) + WS'(w7_r[k][2]) + (WS'(1) <<< 28);
      wv  = (acc >>> 29) + WS'(c7_r[k]);
      if (wv > WS'(32'sh7FFFFFFF)) near8_r[k] <= 32'sh7FFFFFFF;
      else if (wv < -WS'(64'sh80000000)) near8_r[k] <= 32'sh80000000;
      else near8_r[k] <= wv[CoordW-1:0];
    end
    sq = (2*CoordW+2)'(sq7_r[0]) + (2*CoordW+2)'(sq7_r[1]) + (2*CoordW+2)'(sq7_r[2]);
    sat8_r    <= big7_r || (|sq[2*CoordW+1:2*CoordW]);
    rad8_r    <= sq[2*CoordW-1:2];
    inside8_r <= inside7_r;
  end

  // Distance root
  logic               rt_valid;
  logic [RootW-1:0]   rt_root;
  bpsd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v8_r),
    .in_rad    (rad8_r),
    .out_valid (rt_valid),
    .out_root  (rt_root)
  );

  // Hold sideband alongside the root stages
  typedef struct packed {
    logic                     in_box;
    logic                     sat;
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nz;
  } side_t;
  side_t side_r [RootW];
  always_ff @(posedge clk) begin
    side_r[0] <= '{in_box: inside8_r, sat: sat8_r,
                   nx: near8_r[0], ny: near8_r[1], nz: near8_r[2]};
    for (int i = 1; i < RootW; i++) side_r[i] <= side_r[i-1];
  end

  // Output register: sign the distance; the valid strobe is not held
  logic       out_valid_r;
  bpsd_out_t  out_data_r;
  always_ff @(posedge clk) begin
    logic signed [CoordW-1:0] dist_mag;
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= rt_valid;
    dist_mag = side_r[RootW-1].sat ? 32'sh7FFFFFFF : CoordW'({1'b0, rt_root});
    out_data_r.near_x <= side_r[RootW-1].nx;
    out_data_r.near_y <= side_r[RootW-1].ny;
    out_data_r.near_z <= side_r[RootW-1].nz;
    out_data_r.signed_distance <= side_r[RootW-1].in_box ? -dist_mag : dist_mag;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/bpsd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module bpsd_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [bpsd_pkg::RadW-1:0]   in_rad,
  output logic                             out_valid,
  output logic [bpsd_pkg::RootW-1:0]       out_root
);
  import bpsd_pkg::*;

  localparam int RemW = RootW + 3;
  localparam int CurW = RemW + 2;

  logic                valid_r [RootW];
  logic [RemW-1:0]     rem_r   [RootW];
  logic [RootW-1:0]    root_r  [RootW];
  logic [RadW-1:0]     rad_r   [RootW];

  logic [RemW-1:0]     rem_nxt  [RootW];
  logic [RootW-1:0]    root_nxt [RootW];
  logic [RadW-1:0]     rad_nxt  [RootW];

  // Resolve one root bit per stage from the next two radicand bits
  always_comb begin
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RadW-1:0]  rad_in;
    logic [CurW-1:0]  cur;
    logic [CurW-1:0]  trial;
    for (int i = 0; i < RootW; i++) begin
      if (i == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = in_rad;
      end else begin
        rem_in  = rem_r[i-1];
        root_in = root_r[i-1];
        rad_in  = rad_r[i-1];
      end
      cur   = {rem_in, rad_in[RadW-1 -: 2]};
      trial = CurW'({root_in, 2'b01});
      if (cur >= trial) begin
        rem_nxt[i]  = RemW'(cur - trial);
        root_nxt[i] = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = RemW'(cur);
        root_nxt[i] = {root_in[RootW-2:0], 1'b0};
      end
      rad_nxt[i] = {rad_in[RadW-3:0], 2'b00};
    end
  end

  // Advance valid bits and partial roots
  always_ff @(posedge clk) begin
    for (int i = 0; i < RootW; i++) begin
      if (!rst_n) valid_r[i] <= 1'b0;
      else valid_r[i] <= (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i-1];
      rem_r[i]  <= rem_nxt[i];
      root_r[i] <= root_nxt[i];
      rad_r[i]  <= rad_nxt[i];
    end
  end

  assign out_valid = valid_r[RootW-1];
  assign out_root  = root_r[RootW-1];

endmodule
`default_nettype wire

FILE: rtl/bpsd_checker.sv
// Port-level checker for the box point signed distance block, with its bind.
`default_nettype none
module bpsd_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire bpsd_pkg::bpsd_out_t  out_data
);
  import bpsd_pkg::*;

  localparam int Lat = 40;

  // Every accepted beat yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Lat out_valid)
    else $error("accepted beat produced no result");

  // No result without a beat accepted out of reset the latency earlier
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy && rst_n, Lat)))
    else $error("result without accepted beat");

  // The pipeline never refuses a beat
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // A signed distance never takes the most negative value, so the saturated magnitude keeps its sign pair
  a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.signed_distance != 32'sh80000000))
    else $error("distance below negated saturation bound");

endmodule

bind box_point_signed_distance bpsd_checker u_bpsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
